### sv/acsi_pkg.sv
// Shared types and constants for the ANSI CSI terminal parser.
package acsi_pkg;

  // Result kinds carried on out_tuser
  typedef enum logic [2:0] {
    ACT_DRAW  = 3'd0,
    ACT_ERASE = 3'd1,
    ACT_MOVE  = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_COLOR = 3'd4
  } action_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEFAULT_FG = 1'd0;
  localparam cfg_idx_t REG_DEFAULT_BG = 1'd1;

  localparam logic [3:0] DEFAULT_FG_RST = 4'd15;
  localparam logic [3:0] DEFAULT_BG_RST = 4'd1;

  // Stream bytes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] FINAL_LO = 8'h40;  // '@'
  localparam logic [7:0] FINAL_HI = 8'h7E;  // '~'

  // Final bytes that do something
  localparam logic [7:0] CMD_CUP  = 8'h48;  // 'H'
  localparam logic [7:0] CMD_HVP  = 8'h66;  // 'f'
  localparam logic [7:0] CMD_ED   = 8'h4A;  // 'J'
  localparam logic [7:0] CMD_SGR  = 8'h6D;  // 'm'

  localparam logic [15:0] ED_ALL     = 16'd2;
  localparam logic [15:0] SGR_RESET  = 16'd0;
  localparam logic [15:0] SGR_FG_LO  = 16'd30;
  localparam logic [15:0] SGR_FG_HI  = 16'd37;
  localparam logic [15:0] SGR_BG_LO  = 16'd40;
  localparam logic [15:0] SGR_BG_HI  = 16'd47;
  localparam logic [15:0] PARAM_SAT  = 16'hFFFF;
  localparam logic [7:0]  CURSOR_MAX = 8'd255;

  // Cursor position from a 1-based parameter; zero counts as one.
  function automatic logic [7:0] pos_from_param(input logic [15:0] v);
    logic [15:0] m;
    begin
      m = (v == 16'd0) ? 16'd0 : v - 16'd1;
      pos_from_param = (m > 16'(CURSOR_MAX)) ? CURSOR_MAX : m[7:0];
    end
  endfunction

endpackage

### sv/acsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acsi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ansi_csi_terminal_parser.sv
// ANSI CSI terminal parser: cursor/color tracking and ESC [ sequence decoding.
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+-------------------------------------------
// in_     | in  | in_tvalid/tready   | tdata: byte_in[7:0]
// out_    | out | out_tvalid/tready  | tdata: char,col,row,fg,bg; tuser: action;
//         |     |                    | tlast: last_of_run
// cfg_    | in  | cfg_we             | cfg_idx selects register, cfg_wdata[3:0]
//
// One byte at a time; in_tready is high only in the idle state. A plain byte
// passes through accept, decode, plain and load; an SGR final walks the
// parameter RAM one entry a cycle, a pace set by the single RAM read port.
// A lone ESC followed by a plain byte gives two beats, the first without tlast.
// The load cycle stalls while the result register holds an untaken beat;
// that register lets the next byte in while a beat waits on out_tready.
// rst_n is synchronous; no clearing pass (parameter valid bits clear at once).
module ansi_csi_terminal_parser
  import acsi_pkg::*;
#(
  parameter int MAX_PARAMS    = 8,
  parameter int MAX_SEQ_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] char_code, [15:8] col, [23:16] row,
                                  // [27:24] fg_color, [31:28] bg_color
  output logic [2:0]  out_tuser,  // [2:0] action
  output logic        out_tlast,  // last_of_run
  // configuration
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [3:0]  cfg_wdata
);

  localparam int PW = $clog2(MAX_PARAMS);
  localparam int LW = $clog2(MAX_SEQ_BYTES);

  typedef enum logic [1:0] {M_IDLE, M_ESC, M_CSI} mode_t;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a byte
    S_DISP,   // decode byte against parse mode
    S_PLAIN,  // plain byte handling
    S_DIG,    // accumulate digit into parameter
    S_HRD0,   // row parameter arrives
    S_HRD1,   // column parameter arrives
    S_JRD,    // erase-display parameter arrives
    S_SGR,    // walk SGR parameters
    S_OUT     // hand result to output register
  } state_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [PW-1:0]     pidx_r, pidx_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic              bad_r, bad_nxt;
  logic [MAX_PARAMS-1:0] pvalid_r, pvalid_nxt;
  logic              rvalid_r;
  logic [7:0]        col_r, col_nxt, row_r, row_nxt;
  logic [3:0]        fg_r, fg_nxt, bg_r, bg_nxt;
  logic [3:0]        def_fg_r, def_bg_r;
  action_t           res_act_r, res_act_nxt;
  logic [7:0]        res_char_r, res_char_nxt;
  logic              res_last_r, res_last_nxt;
  logic              second_r, second_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;
  action_t           out_act_r, out_act_nxt;
  logic              out_last_r, out_last_nxt;

  // parameter RAM port signals
  logic              ram_we;
  logic [15:0]       ram_wdata, ram_rdata, pval;
  logic [PW-1:0]     ram_raddr;

  // decode helpers
  logic              is_digit, is_final, bad_new;
  logic [LW:0]       len_inc;
  logic [19:0]       acc;
  logic [15:0]       sgr_off;

  acsi_ram #(.WIDTH(16), .DEPTH(MAX_PARAMS)) u_params (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pidx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries of the current sequence read as zero
  assign pval = rvalid_r ? ram_rdata : 16'd0;

  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign is_final = (byte_r >= FINAL_LO) && (byte_r <= FINAL_HI);
  assign len_inc  = {1'b0, len_r} + (LW+1)'(1);
  assign bad_new  = bad_r || (len_inc >= (LW+1)'(MAX_SEQ_BYTES));
  assign acc      = 20'(pval) * 20'd10 + 20'(byte_r[3:0]);
  assign ram_wdata = (acc > 20'(PARAM_SAT)) ? PARAM_SAT : acc[15:0];

  always_comb begin
    case (state_r)
      S_DISP:  ram_raddr = is_digit ? pidx_r : '0;
      S_HRD0:  ram_raddr = PW'(1);
      S_SGR:   ram_raddr = cnt_r + PW'(1);
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    byte_nxt      = byte_r;
    pidx_nxt      = pidx_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    bad_nxt       = bad_r;
    pvalid_nxt    = pvalid_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    res_act_nxt   = res_act_r;
    res_char_nxt  = res_char_r;
    res_last_nxt  = res_last_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_act_nxt   = out_act_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    sgr_off       = 16'd0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_tdata;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        case (mode_r)
          M_IDLE: begin
            if (byte_r == CH_ESC) begin
              mode_nxt  = M_ESC;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_PLAIN;
            end
          end
          M_ESC: begin
            if (byte_r == CH_LBR) begin
              mode_nxt   = M_CSI;
              pvalid_nxt = '0;
              pidx_nxt   = '0;
              len_nxt    = '0;
              bad_nxt    = 1'b0;
              state_nxt  = S_IDLE;
            end else begin
              // lone ESC is drawn; a second ESC opens a new escape
              if (col_r != CURSOR_MAX) col_nxt = col_r + 8'd1;
              res_act_nxt  = ACT_DRAW;
              res_char_nxt = CH_ESC;
              res_last_nxt = (byte_r == CH_ESC);
              second_nxt   = (byte_r != CH_ESC);
              mode_nxt     = (byte_r == CH_ESC) ? M_ESC : M_IDLE;
              state_nxt    = S_OUT;
            end
          end
          M_CSI: begin
            bad_nxt = bad_new;
            if (!bad_new) len_nxt = len_inc[LW-1:0];
            if (is_final) begin
              mode_nxt  = M_IDLE;
              state_nxt = S_IDLE;
              if (!bad_new) begin
                case (byte_r)
                  CMD_CUP, CMD_HVP: state_nxt = S_HRD0;
                  CMD_ED:           state_nxt = S_JRD;
                  CMD_SGR: begin
                    cnt_nxt   = '0;
                    state_nxt = S_SGR;
                  end
                  default:          state_nxt = S_IDLE;
                endcase
              end
            end else if (bad_new) begin
              state_nxt = S_IDLE;
            end else if (is_digit) begin
              state_nxt = S_DIG;
            end else if (byte_r == CH_SEMI) begin
              if (pidx_r == PW'(MAX_PARAMS - 1)) bad_nxt = 1'b1;
              else pidx_nxt = pidx_r + PW'(1);
              state_nxt = S_IDLE;
            end else begin
              bad_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_PLAIN: begin
        res_last_nxt = 1'b1;
        res_char_nxt = 8'd0;
        second_nxt   = 1'b0;
        state_nxt    = S_OUT;
        case (byte_r)
          CH_LF: begin
            if (row_r != CURSOR_MAX) row_nxt = row_r + 8'd1;
            col_nxt     = 8'd0;
            res_act_nxt = ACT_MOVE;
          end
          CH_CR: begin
            col_nxt     = 8'd0;
            res_act_nxt = ACT_MOVE;
          end
          CH_BS: begin
            if (col_r == 8'd0) begin
              state_nxt = S_IDLE;
            end else begin
              col_nxt = col_r - 8'd1;
            end
            res_act_nxt = ACT_ERASE;
          end
          default: begin
            if (col_r != CURSOR_MAX) col_nxt = col_r + 8'd1;
            res_act_nxt  = ACT_DRAW;
            res_char_nxt = byte_r;
          end
        endcase
      end

      S_DIG: begin
        ram_we             = 1'b1;
        pvalid_nxt[pidx_r] = 1'b1;
        state_nxt          = S_IDLE;
      end

      S_HRD0: begin
        row_nxt   = pos_from_param(pval);
        state_nxt = S_HRD1;
      end

      S_HRD1: begin
        col_nxt      = pos_from_param(pval);
        res_act_nxt  = ACT_MOVE;
        res_char_nxt = 8'd0;
        res_last_nxt = 1'b1;
        second_nxt   = 1'b0;
        state_nxt    = S_OUT;
      end

      S_JRD: begin
        res_act_nxt  = ACT_CLEAR;
        res_char_nxt = 8'd0;
        res_last_nxt = 1'b1;
        second_nxt   = 1'b0;
        state_nxt    = (pval == ED_ALL) ? S_OUT : S_IDLE;
      end

      S_SGR: begin
        if (pval == SGR_RESET) begin
          fg_nxt = def_fg_r;
          bg_nxt = def_bg_r;
        end else if (pval >= SGR_FG_LO && pval <= SGR_FG_HI) begin
          sgr_off = pval - SGR_FG_LO;
          fg_nxt  = sgr_off[3:0];
        end else if (pval >= SGR_BG_LO && pval <= SGR_BG_HI) begin
          sgr_off = pval - SGR_BG_LO;
          bg_nxt  = sgr_off[3:0];
        end
        if (cnt_r == pidx_r) begin
          res_act_nxt  = ACT_COLOR;
          res_char_nxt = 8'd0;
          res_last_nxt = 1'b1;
          second_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          cnt_nxt = cnt_r + PW'(1);
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {bg_r, fg_r, row_r, col_r, res_char_r};
          out_act_nxt   = res_act_r;
          out_last_nxt  = res_last_r;
          state_nxt     = second_r ? S_PLAIN : S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_IDLE;
      pidx_r      <= '0;
      cnt_r       <= '0;
      len_r       <= '0;
      bad_r       <= 1'b0;
      pvalid_r    <= '0;
      rvalid_r    <= 1'b0;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
      fg_r        <= DEFAULT_FG_RST;
      bg_r        <= DEFAULT_BG_RST;
      def_fg_r    <= DEFAULT_FG_RST;
      def_bg_r    <= DEFAULT_BG_RST;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pidx_r      <= pidx_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      bad_r       <= bad_nxt;
      pvalid_r    <= pvalid_nxt;
      rvalid_r    <= pvalid_r[ram_raddr];
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_DEFAULT_FG: def_fg_r <= cfg_wdata;
          REG_DEFAULT_BG: def_bg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    // payload, no reset
    byte_r     <= byte_nxt;
    res_act_r  <= res_act_nxt;
    res_char_r <= res_char_nxt;
    res_last_r <= res_last_nxt;
    out_data_r <= out_data_nxt;
    out_act_r  <= out_act_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // no byte is taken while the previous one is still in work
  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("byte accepted while previous one still in work");

  // the first beat of a two-beat run holds off new input
  a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input open while a run is incomplete");

  // entering a sequence clears the parameter state
  a_csi_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP && mode_r == M_ESC && byte_r == CH_LBR)
      |=> (pvalid_r == '0 && !bad_r && pidx_r == '0 && mode_r == M_CSI))
    else $error("sequence state not cleared on CSI entry");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the ANSI CSI terminal parser: byte stream in, action beats out.
`timescale 1ns / 100ps

module testbench;
  import acsi_pkg::*;

  // Parser limits of the default build
  localparam int unsigned NPRM       = 8;
  localparam int unsigned SEQ_MAX    = 32;
  // Idle cycles after the last result before touching config or ending;
  // covers an SGR final walking all parameters plus a byte with no result.
  localparam int unsigned SETTLE     = 24;
  localparam int unsigned DRAIN_MAX  = 20000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned PHASE_BYTES = 330;

  // One output beat, fields in the order they appear on the bus
  typedef struct packed {
    action_t    act;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       last;
  } beat_t;

  // Terminal predictor plus the queue of beats still owed by the DUT.
  class term_scoreboard;
    typedef enum {SCAN_TEXT, SCAN_ESC, SCAN_CSI} scan_t;

    scan_t       mode;
    int unsigned prm[NPRM];
    int unsigned pidx;
    int unsigned slen;
    bit          bad;
    logic [7:0]  col, row;
    logic [3:0]  fg, bg, dfg, dbg;
    beat_t       want[$];
    int unsigned faults;

    function new();
      mode = SCAN_TEXT;
      foreach (prm[i]) prm[i] = 0;
      pidx = 0;
      slen = 0;
      bad = 1'b0;
      col = '0;
      row = '0;
      dfg = DEFAULT_FG_RST;
      dbg = DEFAULT_BG_RST;
      fg = dfg;
      bg = dbg;
      faults = 0;
    endfunction

    // Defaults only land in the current colors at the next SGR 0
    function void set_defaults(logic [3:0] f, logic [3:0] b);
      dfg = f;
      dbg = b;
    endfunction

    function int unsigned pending();
      return want.size();
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    function void emit(action_t a, logic [7:0] c);
      beat_t r;
      r.act = a;
      r.ch = c;
      r.col = col;
      r.row = row;
      r.fg = fg;
      r.bg = bg;
      r.last = 1'b0;
      want.push_back(r);
    endfunction

    // 1-based position parameter, zero or missing counts as one
    function logic [7:0] to_cell(int unsigned v);
      int unsigned m;
      m = (v == 0) ? 0 : v - 1;
      return (m > CURSOR_MAX) ? CURSOR_MAX : m[7:0];
    endfunction

    function void plain(logic [7:0] b);
      if (b == CH_LF) begin
        if (row < CURSOR_MAX) row++;
        col = '0;
        emit(ACT_MOVE, 8'h00);
      end else if (b == CH_CR) begin
        col = '0;
        emit(ACT_MOVE, 8'h00);
      end else if (b == CH_BS) begin
        if (col != 0) begin
          col--;
          emit(ACT_ERASE, 8'h00);
        end
      end else begin
        if (col < CURSOR_MAX) col++;
        emit(ACT_DRAW, b);
      end
    endfunction

    function void csi(logic [7:0] b);
      int unsigned idx, v;
      // length counts the final byte too
      if (slen + 1 >= SEQ_MAX) bad = 1'b1;
      else slen++;
      if (b >= FINAL_LO && b <= FINAL_HI) begin
        mode = SCAN_TEXT;
        if (!bad) begin
          case (b)
            CMD_CUP, CMD_HVP: begin
              row = to_cell(prm[0]);
              col = to_cell(prm[1]);
              emit(ACT_MOVE, 8'h00);
            end
            CMD_ED: begin
              if (prm[0] == ED_ALL) emit(ACT_CLEAR, 8'h00);
            end
            CMD_SGR: begin
              for (int i = 0; i <= pidx && i < NPRM; i++) begin
                v = prm[i];
                if (v == SGR_RESET) begin
                  fg = dfg;
                  bg = dbg;
                end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
                  fg = 4'(v - SGR_FG_LO);
                end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
                  bg = 4'(v - SGR_BG_LO);
                end
              end
              emit(ACT_COLOR, 8'h00);
            end
            default: ;
          endcase
        end
      end else if (!bad) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          idx = (pidx < NPRM) ? pidx : NPRM - 1;
          v = prm[idx] * 10 + (b - CH_ZERO);
          prm[idx] = (v > PARAM_SAT) ? PARAM_SAT : v;
        end else if (b == CH_SEMI) begin
          if (pidx + 1 >= NPRM) bad = 1'b1;
          else pidx++;
        end else begin
          bad = 1'b1;
        end
      end
    endfunction

    // Called for every accepted input beat
    function void note_byte(logic [7:0] b);
      int unsigned base;
      base = want.size();
      case (mode)
        SCAN_CSI: csi(b);
        SCAN_ESC: begin
          if (b == CH_LBR) begin
            mode = SCAN_CSI;
            foreach (prm[i]) prm[i] = 0;
            pidx = 0;
            slen = 0;
            bad = 1'b0;
          end else begin
            // lone ESC is drawn, then the byte is taken on its own
            mode = SCAN_TEXT;
            plain(CH_ESC);
            if (b == CH_ESC) mode = SCAN_ESC;
            else plain(b);
          end
        end
        default: begin
          if (b == CH_ESC) mode = SCAN_ESC;
          else plain(b);
        end
      endcase
      if (want.size() > base) want[want.size() - 1].last = 1'b1;
    endfunction

    // Called for every accepted output beat
    function void check_beat(logic [31:0] d, logic [2:0] u, logic l);
      beat_t got, exp_b;
      got.act = action_t'(u);
      got.ch = d[7:0];
      got.col = d[15:8];
      got.row = d[23:16];
      got.fg = d[27:24];
      got.bg = d[31:28];
      got.last = l;
      if (want.size() == 0) begin
        flag($sformatf("unexpected beat act=%0d ch=%02h col=%0d row=%0d fg=%0d bg=%0d last=%0b",
                       got.act, got.ch, got.col, got.row, got.fg, got.bg, got.last));
        return;
      end
      exp_b = want.pop_front();
      if (got !== exp_b)
        flag($sformatf({"beat mismatch: exp act=%0d ch=%02h col=%0d row=%0d fg=%0d bg=%0d ",
                        "last=%0b / got act=%0d ch=%02h col=%0d row=%0d fg=%0d bg=%0d last=%0b"},
                       exp_b.act, exp_b.ch, exp_b.col, exp_b.row, exp_b.fg, exp_b.bg,
                       exp_b.last, got.act, got.ch, got.col, got.row, got.fg, got.bg,
                       got.last));
    endfunction

    // Anything still owed at the end is a failure
    function void close();
      if (want.size() != 0)
        flag($sformatf("%0d expected beats never arrived", want.size()));
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] byte_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [7:0] char, [15:8] col, [23:16] row,
                                     // [27:24] fg, [31:28] bg
  logic [2:0]  out_tuser;            // [2:0] action
  logic        out_tlast;            // last beat for this input byte
  logic        cfg_we     = 1'b0;
  cfg_idx_t    cfg_idx    = REG_DEFAULT_FG;
  logic [3:0]  cfg_wdata  = 4'd0;

  term_scoreboard sb;

  // Handshake shaping knobs, changed only between phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  ansi_csi_terminal_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Monitors: sample pre-edge values, so ordering within the step is moot
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  // The hold is counted here so the sender keeps pushing bytes meanwhile.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Drivers; every task is entered right after a rising edge
  // ---------------------------------------------------------------------

  // One byte on the input stream, with an optional idle gap in front.
  // tvalid stays high across back-to-back beats.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Both registers back to back, one write per edge
  task automatic set_defaults(input logic [3:0] f, input logic [3:0] b);
    cfg_we <= 1'b1;
    cfg_idx <= REG_DEFAULT_FG;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_idx <= REG_DEFAULT_BG;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_defaults(f, b);
  endtask

  // Hold the sender until every owed beat is out, then let the block settle
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed CSI sequences with random content,
  // text runs, and a share of over-long, broken and lone-ESC noise.
  task automatic send_mixed(input int unsigned quota);
    int unsigned sent, n, i, j, v, pick;
    logic [7:0]  seq[$];
    logic [7:0]  b;
    string       num;
    sent = 0;
    while (sent < quota) begin
      seq.delete();
      pick = $urandom_range(99);
      if (pick < 35) begin
        // text run, control bytes mixed in
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          v = $urandom_range(99);
          if (v < 70) b = 8'($urandom_range(8'h20, 8'h7E));
          else if (v < 80) begin
            case ($urandom_range(2))
              0: b = CH_LF;
              1: b = CH_CR;
              default: b = CH_BS;
            endcase
          end else b = 8'($urandom_range(255));
          seq.push_back(b);
        end
      end else if (pick < 80) begin
        // well-formed sequence; 9 params trips the param limit
        seq.push_back(CH_ESC);
        seq.push_back(CH_LBR);
        n = ($urandom_range(9) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
          if (i > 0) seq.push_back(CH_SEMI);
          case ($urandom_range(5))
            0: v = $urandom_range(2);
            1: v = $urandom_range(SGR_FG_LO, SGR_FG_HI);
            2: v = $urandom_range(SGR_BG_LO, SGR_BG_HI);
            3: v = $urandom_range(1, 80);
            4: v = $urandom_range(200, 300);
            default: v = ($urandom_range(3) == 0) ? $urandom_range(60000, 99999)
                                                  : $urandom_range(9);
          endcase
          num = $sformatf("%0d", v);
          if ($urandom_range(15) == 0) num = {"0", num};
          if ($urandom_range(9) == 0) num = "";
          for (j = 0; j < num.len(); j++) seq.push_back(num[j]);
        end
        v = $urandom_range(9);
        if (v < 2) b = CMD_CUP;
        else if (v < 3) b = CMD_HVP;
        else if (v < 5) b = CMD_ED;
        else if (v < 8) b = CMD_SGR;
        else b = 8'($urandom_range(FINAL_LO, FINAL_HI));
        seq.push_back(b);
      end else if (pick < 88) begin
        // around the length limit
        seq.push_back(CH_ESC);
        seq.push_back(CH_LBR);
        n = $urandom_range(26, 40);
        for (i = 0; i < n; i++)
          seq.push_back(($urandom_range(11) == 0) ? CH_SEMI
                                                  : 8'(CH_ZERO + $urandom_range(9)));
        seq.push_back(($urandom_range(1) == 0) ? CMD_SGR : CMD_CUP);
      end else if (pick < 95) begin
        // bad intermediate byte, ESC among them
        seq.push_back(CH_ESC);
        seq.push_back(CH_LBR);
        n = $urandom_range(3);
        for (i = 0; i < n; i++) seq.push_back(8'(CH_ZERO + $urandom_range(9)));
        b = 8'($urandom_range(255));
        if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI ||
            (b >= FINAL_LO && b <= FINAL_HI)) b = 8'h3F;
        if ($urandom_range(3) == 0) b = CH_ESC;
        seq.push_back(b);
        n = $urandom_range(3);
        for (i = 0; i < n; i++) seq.push_back(8'(CH_ZERO + $urandom_range(9)));
        case ($urandom_range(2))
          0: seq.push_back(CMD_SGR);
          1: seq.push_back(CMD_CUP);
          default: seq.push_back(CMD_ED);
        endcase
      end else begin
        // ESC not followed by '['
        seq.push_back(CH_ESC);
        b = 8'($urandom_range(255));
        if (b == CH_LBR) b = CH_ESC;
        seq.push_back(b);
      end
      foreach (seq[k]) send_byte(seq[k]);
      sent += seq.size();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [7:0]  intro[$];
    logic [3:0]  fg_plan[5];
    logic [3:0]  bg_plan[5];
    int unsigned idle_plan[5];
    int unsigned stall_plan[5];

    sb = new();
    // directed: byte extremes, backspace both ways, lone ESC (two beats),
    // ESC ESC then clear, default home, SGR colors, SGR with no params
    intro = '{8'h00, 8'hFF, CH_BS, CH_CR, CH_BS, CH_LF,
              CH_ESC, "A",
              CH_ESC, CH_ESC, CH_LBR, "2", CMD_ED,
              CH_ESC, CH_LBR, CMD_CUP,
              CH_ESC, CH_LBR, "3", "1", CH_SEMI, "4", "2", CMD_SGR,
              CH_ESC, CH_LBR, CMD_SGR};
    // register settings per phase, extremes included
    fg_plan = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'd15, 4'd0};
    bg_plan = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'd0, 4'd15};
    idle_plan  = '{0, 51, 0, 28, 0};
    stall_plan = '{0, 0, 51, 28, 0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_defaults(4'd7, 4'd2);
    foreach (intro[i]) send_byte(intro[i]);

    for (int p = 0; p < 5; p++) begin
      // sender parks until everything owed has come back
      in_tvalid <= 1'b0;
      drain_results();
      set_defaults(fg_plan[p], bg_plan[p]);
      send_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      // long receiver hold-off while bytes keep coming: backs up the block
      if (p == 2) hold_reqs <= hold_reqs + 1;
      send_mixed(PHASE_BYTES);
    end

    in_tvalid <= 1'b0;
    drain_results();
    sb.close();
    if (sb.faults == 0) begin
      $display("ansi_csi_terminal_parser verification clean");
    end else begin
      $display("ansi_csi_terminal_parser verification failed");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run
  initial begin
    #(20_000_000);
    $display("ansi_csi_terminal_parser verification failed");
    $finish;
  end

endmodule
